/* hw/rtl/fsp_pkg.sv */
`default_nettype none
package fsp_pkg;

  localparam int FFT_POINTS_DEF = 512;
  localparam int COMPONENT_BITS_DEF = 36;

  localparam int SAMPLE_W = 16;
  localparam int HZ_W = 6;
  localparam int BINS_W = 8;
  localparam int F0_W = 14;

  // register indexes
  localparam logic REG_HZ_PER_BIN = 1'b0;
  localparam logic REG_SEARCH_BINS = 1'b1;

  localparam logic [HZ_W-1:0] HZ_RESET = 6'd31;
  localparam logic [BINS_W-1:0] BINS_RESET = 8'd50;

  localparam logic [63:0] Q30_ONE = 64'h4000_0000;
  localparam logic [63:0] Q30_HALF = 64'h2000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // taylor term denominators
  localparam logic [63:0] COS_DEN [8] = '{64'd1, 64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                          64'd132, 64'd182};
  localparam logic [63:0] SIN_DEN [8] = '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                          64'd156, 64'd210};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } fsp_in_t;

  typedef struct packed {
    logic [F0_W-1:0] f0_hz;
    logic            peak_found;
  } fsp_out_t;

  function automatic logic [63:0] cos_series(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] h;
    y = (x * x + Q30_HALF) >> 30;
    h = Q30_ONE;
    for (int j = 7; j >= 1; j--) begin
      h = Q30_ONE - (((y * h + Q30_HALF) >> 30) / COS_DEN[j]);
    end
    return h;
  endfunction

  function automatic logic [63:0] sin_series(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] h;
    y = (x * x + Q30_HALF) >> 30;
    h = Q30_ONE;
    for (int j = 7; j >= 1; j--) begin
      h = Q30_ONE - (((y * h + Q30_HALF) >> 30) / SIN_DEN[j]);
    end
    return (x * h + Q30_HALF) >> 30;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/fft_spectral_peak_pitch.sv */
`default_nettype none
// channel   ports                           handshake
// -------   -----------------------------   ----------------------------------
// frame     frame_word (sample, last)       taken when start & !busy
// pitch     pitch_word (f0_hz, peak_found)  valid for the one cycle done is high
// config    cfg_we, cfg_index, cfg_data     written when cfg_we is high
//
// samples are taken one per cycle while filling; a word with last set starts analysis
// analysis: each sample is windowed and loaded in states LD0-LD2, then states B0-B8 run
// for each of (N/2)*log2(N) butterflies, then P0-P8 for each power bin over search_bins+2
// bins at most, plus one compare (CMP) per candidate
// all of it runs through the one shared multiplier, one product per cycle
// busy is high from the cycle after the last word through the done cycle
// rst clears the sequencer, fill count and registers; the receiver cannot stall
module fft_spectral_peak_pitch #(
  parameter int FFT_POINTS = fsp_pkg::FFT_POINTS_DEF,
  parameter int COMPONENT_BITS = fsp_pkg::COMPONENT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire fsp_pkg::fsp_in_t       frame_word,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [7:0]             cfg_data,
  output logic                        done,
  output fsp_pkg::fsp_out_t           pitch_word
);

  import fsp_pkg::*;

  localparam int AW = $clog2(FFT_POINTS);
  localparam int SW = $clog2(AW);
  localparam int CB = COMPONENT_BITS;
  localparam int HB = (CB + 1) / 2;
  localparam int MB = (HB + 1 > 17) ? HB + 1 : 17;
  localparam int PB = CB + MB;
  localparam int TW = CB + 3;
  localparam int PW = 2 * CB;

  localparam logic [63:0] WIN_DEN = 64'(FFT_POINTS - 1);
  localparam logic [63:0] TW_DEN = 64'(FFT_POINTS);

  localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_LO = TW'(-(64'sd1 <<< (CB - 1)));

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_LD0  = 5'd1;
  localparam logic [4:0] ST_LD1  = 5'd2;
  localparam logic [4:0] ST_LD2  = 5'd3;
  localparam logic [4:0] ST_B0   = 5'd4;
  localparam logic [4:0] ST_B1   = 5'd5;
  localparam logic [4:0] ST_B2   = 5'd6;
  localparam logic [4:0] ST_B3   = 5'd7;
  localparam logic [4:0] ST_B4   = 5'd8;
  localparam logic [4:0] ST_B5   = 5'd9;
  localparam logic [4:0] ST_B6   = 5'd10;
  localparam logic [4:0] ST_B7   = 5'd11;
  localparam logic [4:0] ST_B8   = 5'd12;
  localparam logic [4:0] ST_P0   = 5'd13;
  localparam logic [4:0] ST_P1   = 5'd14;
  localparam logic [4:0] ST_P2   = 5'd15;
  localparam logic [4:0] ST_P3   = 5'd16;
  localparam logic [4:0] ST_P4   = 5'd17;
  localparam logic [4:0] ST_P5   = 5'd18;
  localparam logic [4:0] ST_P6   = 5'd19;
  localparam logic [4:0] ST_P7   = 5'd20;
  localparam logic [4:0] ST_P8   = 5'd21;
  localparam logic [4:0] ST_CMP  = 5'd22;
  localparam logic [4:0] ST_DONE = 5'd23;

  typedef logic [15:0] win_rom_t [FFT_POINTS/2];
  typedef logic [33:0] tw_rom_t [FFT_POINTS/2];

  function automatic logic [63:0] div_den(input logic [63:0] v, input logic use_win);
    return use_win ? v / WIN_DEN : v / TW_DEN;
  endfunction

  // {cos, sin} of 2*pi*p/den in q30
  function automatic logic [127:0] trig_q30(input logic [63:0] p, input logic use_win);
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] ct;
    logic [63:0] st;
    logic [63:0] c;
    logic [63:0] s;
    d = use_win ? WIN_DEN : TW_DEN;
    a = p << 2;
    q = div_den(a, use_win);
    r = a - q * d;
    if (2 * r <= d) begin
      x = div_den(HALF_PI_Q30 * r + (d >> 1), use_win);
      ct = cos_series(x);
      st = sin_series(x);
    end else begin
      x = div_den(HALF_PI_Q30 * (d - r) + (d >> 1), use_win);
      ct = sin_series(x);
      st = cos_series(x);
    end
    case (q[1:0])
      2'd0: begin c = ct; s = st; end
      2'd1: begin c = -st; s = ct; end
      2'd2: begin c = -ct; s = -st; end
      default: begin c = st; s = -ct; end
    endcase
    return {c, s};
  endfunction

  // window is symmetric, only the lower half is kept
  function automatic win_rom_t build_win();
    win_rom_t t;
    logic [127:0] cs;
    logic [63:0] w;
    for (int i = 0; i < FFT_POINTS / 2; i++) begin
      cs = trig_q30(64'(i), 1'b1);
      w = (Q30_ONE - cs[127:64] + 64'h8000) >> 16;
      t[i] = (w > 64'd32767) ? 16'd32767 : w[15:0];
    end
    return t;
  endfunction

  function automatic tw_rom_t build_tw();
    tw_rom_t t;
    logic [127:0] cs;
    logic signed [63:0] c;
    logic signed [63:0] s;
    logic signed [63:0] cr;
    logic signed [63:0] sr;
    for (int i = 0; i < FFT_POINTS / 2; i++) begin
      cs = trig_q30(64'(i), 1'b0);
      c = cs[127:64];
      s = cs[63:0];
      cr = (c + 64'sd16384) >>> 15;
      sr = (-s + 64'sd16384) >>> 15;
      t[i] = {cr[16:0], sr[16:0]};
    end
    return t;
  endfunction

  localparam win_rom_t WIN_ROM = build_win();
  localparam tw_rom_t TW_ROM = build_tw();

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int k = 0; k < AW; k++) begin
      r[k] = v[AW-1-k];
    end
    return r;
  endfunction

  function automatic logic signed [CB-1:0] sat_comp(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] t;
    t = v;
    if (v > SAT_HI) t = SAT_HI;
    if (v < SAT_LO) t = SAT_LO;
    return t[CB-1:0];
  endfunction

  logic [4:0]          state;
  logic [AW:0]         fill;
  logic [HZ_W-1:0]     hz_per_bin;
  logic [BINS_W-1:0]   search_bins;
  logic [AW-1:0]       idx;
  logic [SW-1:0]       stage;
  logic [AW-2:0]       bfly;
  logic [15:0]         win_q;
  logic [33:0]         tw_q;
  logic signed [CB-1:0] ar;
  logic signed [CB-1:0] ai;
  logic signed [CB-1:0] br;
  logic signed [CB-1:0] bi;
  logic signed [TW-1:0] tr;
  logic signed [TW-1:0] ti;
  logic signed [PB-1:0] prod;
  logic [CB-1:0]       mre;
  logic [CB-1:0]       mim;
  logic [PW-1:0]       acc;
  logic [PW-1:0]       prv;
  logic [PW-1:0]       cur;
  logic [PW-1:0]       nxt;
  logic [1:0]          pfill;
  logic [AW-1:0]       bin;
  logic [BINS_W-1:0]   cand;
  logic [F0_W-1:0]     f0;
  logic                found;

  logic                accept;
  logic                f_we;
  logic [15:0]         f_rdata;
  logic                s_we;
  logic [AW-1:0]       s_waddr;
  logic [AW-1:0]       s_raddr;
  logic [PW-1:0]       s_wdata;
  logic [PW-1:0]       s_rdata;
  logic signed [CB-1:0] s_re;
  logic signed [CB-1:0] s_im;
  logic [AW-2:0]       jmask;
  logic [AW-2:0]       jpos;
  logic [AW-1:0]       ia;
  logic [AW-1:0]       ib;
  logic [AW-2:0]       tw_idx;
  logic [AW-2:0]       win_idx;
  logic signed [16:0]  wr;
  logic signed [16:0]  wi;
  logic signed [CB-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [TW-1:0] rnd_tw;
  logic signed [TW-1:0] rnd_win;
  logic [PW-1:0]       sq;
  logic [PW-1:0]       pw;
  logic [HB-1:0]       re_lo;
  logic [HB-1:0]       re_hi;
  logic [HB-1:0]       im_lo;
  logic [HB-1:0]       im_hi;
  logic [15:0]         x_in;
  logic                hit;

  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);
  assign pitch_word.f0_hz = f0;
  assign pitch_word.peak_found = found;
  assign f_we = accept && (fill < (AW+1)'(FFT_POINTS));

  fsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(FFT_POINTS)) u_frame (
    .clk   (clk),
    .we    (f_we),
    .waddr (fill[AW-1:0]),
    .wdata (frame_word.sample),
    .raddr (idx),
    .rdata (f_rdata)
  );

  fsp_ram #(.WIDTH(PW), .DEPTH(FFT_POINTS)) u_spec (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign s_re = s_rdata[PW-1:CB];
  assign s_im = s_rdata[CB-1:0];

  // butterfly addressing
  assign jmask = ~({(AW-1){1'b1}} << stage);
  assign jpos = bfly & jmask;
  assign ia = {bfly & ~jmask, 1'b0} | {1'b0, jpos};
  assign ib = ia | (AW'(1) << stage);
  assign tw_idx = jpos << (SW'(AW - 1) - stage);
  assign win_idx = idx[AW-1] ? ~idx[AW-2:0] : idx[AW-2:0];
  assign wr = tw_q[33:17];
  assign wi = tw_q[16:0];

  assign re_lo = mre[HB-1:0];
  assign re_hi = HB'(mre >> HB);
  assign im_lo = mim[HB-1:0];
  assign im_hi = HB'(mim >> HB);

  assign x_in = ({1'b0, idx} < fill) ? f_rdata : '0;
  assign rnd_tw = TW'((prod + PB'(16384)) >>> 15);
  assign rnd_win = TW'((prod + PB'(64)) >>> 7);
  assign sq = PW'(prod[2*HB-1:0]);
  assign pw = acc + (sq << (2 * HB));
  assign hit = (cur >= prv) && (nxt < cur);

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_LD1: begin ma = CB'($signed(x_in)); mb = MB'(win_q); end
      ST_B2:  begin ma = s_re; mb = MB'(wr); end
      ST_B3:  begin ma = bi; mb = MB'(wi); end
      ST_B4:  begin ma = br; mb = MB'(wi); end
      ST_B5:  begin ma = bi; mb = MB'(wr); end
      ST_P2:  begin ma = CB'(re_lo); mb = MB'(re_lo); end
      ST_P3:  begin ma = CB'(re_hi); mb = MB'(re_lo); end
      ST_P4:  begin ma = CB'(re_hi); mb = MB'(re_hi); end
      ST_P5:  begin ma = CB'(im_lo); mb = MB'(im_lo); end
      ST_P6:  begin ma = CB'(im_hi); mb = MB'(im_lo); end
      ST_P7:  begin ma = CB'(im_hi); mb = MB'(im_hi); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // spectrum memory ports
  always_comb begin
    s_we = 1'b0;
    s_waddr = ia;
    s_wdata = {sat_comp(TW'(ar) + tr), sat_comp(TW'(ai) + ti)};
    s_raddr = bin;
    unique case (state)
      ST_LD2: begin
        s_we = 1'b1;
        s_waddr = bitrev(idx);
        s_wdata = {sat_comp(rnd_win), {CB{1'b0}}};
      end
      ST_B0: s_raddr = ia;
      ST_B1: s_raddr = ib;
      ST_B7: s_we = 1'b1;
      ST_B8: begin
        s_we = 1'b1;
        s_waddr = ib;
        s_wdata = {sat_comp(TW'(ar) - tr), sat_comp(TW'(ai) - ti)};
      end
      default: s_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      hz_per_bin <= HZ_RESET;
      search_bins <= BINS_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HZ_PER_BIN) begin
          hz_per_bin <= cfg_data[HZ_W-1:0];
        end else if (cfg_index == REG_SEARCH_BINS) begin
          search_bins <= cfg_data;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (f_we) begin
              fill <= fill + 1'b1;
            end
            if (frame_word.last) begin
              idx <= '0;
              state <= ST_LD0;
            end
          end
        end
        ST_LD0: begin
          win_q <= WIN_ROM[win_idx];
          state <= ST_LD1;
        end
        ST_LD1: state <= ST_LD2;
        ST_LD2: begin
          if (idx == AW'(FFT_POINTS - 1)) begin
            fill <= '0;
            stage <= '0;
            bfly <= '0;
            state <= ST_B0;
          end else begin
            idx <= idx + 1'b1;
            state <= ST_LD0;
          end
        end
        ST_B0: begin
          tw_q <= TW_ROM[tw_idx];
          state <= ST_B1;
        end
        ST_B1: begin
          ar <= s_re;
          ai <= s_im;
          state <= ST_B2;
        end
        ST_B2: begin
          br <= s_re;
          bi <= s_im;
          state <= ST_B3;
        end
        ST_B3: begin
          tr <= rnd_tw;
          state <= ST_B4;
        end
        ST_B4: begin
          tr <= tr - rnd_tw;
          state <= ST_B5;
        end
        ST_B5: begin
          ti <= rnd_tw;
          state <= ST_B6;
        end
        ST_B6: begin
          ti <= ti + rnd_tw;
          state <= ST_B7;
        end
        ST_B7: state <= ST_B8;
        ST_B8: begin
          bfly <= bfly + 1'b1;
          state <= ST_B0;
          if (bfly == {(AW-1){1'b1}}) begin
            stage <= stage + 1'b1;
            if (stage == SW'(AW - 1)) begin
              bin <= AW'(1);
              cand <= BINS_W'(1);
              pfill <= '0;
              if (search_bins == '0) begin
                f0 <= '0;
                found <= 1'b0;
                state <= ST_DONE;
              end else begin
                state <= ST_P0;
              end
            end
          end
        end
        ST_P0: state <= ST_P1;
        ST_P1: begin
          mre <= s_re[CB-1] ? CB'(-s_re) : CB'(s_re);
          mim <= s_im[CB-1] ? CB'(-s_im) : CB'(s_im);
          state <= ST_P2;
        end
        ST_P2: state <= ST_P3;
        ST_P3: begin
          acc <= sq;
          state <= ST_P4;
        end
        ST_P4: begin
          acc <= acc + (sq << (HB + 1));
          state <= ST_P5;
        end
        ST_P5: begin
          acc <= acc + (sq << (2 * HB));
          state <= ST_P6;
        end
        ST_P6: begin
          acc <= acc + sq;
          state <= ST_P7;
        end
        ST_P7: begin
          acc <= acc + (sq << (HB + 1));
          state <= ST_P8;
        end
        ST_P8: begin
          bin <= bin + 1'b1;
          if (pfill == 2'd0) begin
            prv <= pw;
            pfill <= 2'd1;
            state <= ST_P0;
          end else if (pfill == 2'd1) begin
            cur <= pw;
            pfill <= 2'd2;
            state <= ST_P0;
          end else begin
            nxt <= pw;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (hit) begin
            f0 <= F0_W'(hz_per_bin) * F0_W'(cand);
            found <= 1'b1;
            state <= ST_DONE;
          end else if (cand == search_bins) begin
            f0 <= '0;
            found <= 1'b0;
            state <= ST_DONE;
          end else begin
            prv <= cur;
            cur <= nxt;
            cand <= cand + 1'b1;
            state <= ST_P0;
          end
        end
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fsp_ram.sv */
`default_nettype none
module fsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
module testbench;
  import fsp_pkg::*;

  localparam int NPTS = 512;
  localparam longint CLAMP_HI = (64'sd1 <<< 35) - 1;
  localparam longint CLAMP_LO = -(64'sd1 <<< 35);
  localparam longint unsigned ONE_Q30 = 64'h4000_0000;
  localparam longint unsigned HALF_Q30 = 64'h2000_0000;
  localparam longint unsigned QUARTER_TURN = 64'd1686629713;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  fsp_in_t frame_word;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_data;
  logic done;
  fsp_out_t pitch_word;

  fft_spectral_peak_pitch dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .frame_word(frame_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .pitch_word(pitch_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pitch detector model state
  int hann_rom [NPTS];
  int twid_cos [NPTS/2];
  int twid_sin [NPTS/2];
  int samples_held [NPTS];
  longint bin_re [NPTS];
  longint bin_im [NPTS];
  int unsigned samples_in;
  logic [5:0] hz_step;
  logic [7:0] bins_to_search;

  fsp_out_t pitch_q [$];
  int fail_count;
  int words_sent;
  int frames_sent;
  bit allow_gaps;

  function automatic longint unsigned cos_poly(longint unsigned x);
    longint unsigned y, h;
    y = (x * x + HALF_Q30) >> 30;
    h = ONE_Q30;
    for (int j = 7; j >= 1; j--) h = ONE_Q30 - (((y * h + HALF_Q30) >> 30) / ((2*j-1) * (2*j)));
    return h;
  endfunction

  function automatic longint unsigned sin_poly(longint unsigned x);
    longint unsigned y, h;
    y = (x * x + HALF_Q30) >> 30;
    h = ONE_Q30;
    for (int j = 7; j >= 1; j--) h = ONE_Q30 - (((y * h + HALF_Q30) >> 30) / ((2*j) * (2*j+1)));
    return (x * h + HALF_Q30) >> 30;
  endfunction

  function automatic void angle_q30(input longint unsigned p, input longint unsigned d,
                                    output longint c, output longint s);
    longint unsigned a, q, r, x;
    longint ct, st;
    a = 4 * p;
    q = a / d;
    r = a % d;
    if (2 * r <= d) begin
      x = (QUARTER_TURN * r + d / 2) / d;
      ct = longint'(cos_poly(x));
      st = longint'(sin_poly(x));
    end else begin
      x = (QUARTER_TURN * (d - r) + d / 2) / d;
      ct = longint'(sin_poly(x));
      st = longint'(cos_poly(x));
    end
    case (q & 3)
      0: begin c = ct; s = st; end
      1: begin c = -st; s = ct; end
      2: begin c = -ct; s = -st; end
      default: begin c = st; s = -ct; end
    endcase
  endfunction

  function automatic void fill_trig_tables();
    longint c, s, w;
    for (int i = 0; i < NPTS; i++) begin
      angle_q30(i, NPTS - 1, c, s);
      w = (longint'(ONE_Q30) - c + 32768) >>> 16;
      hann_rom[i] = (w > 32767) ? 32767 : int'(w);
    end
    for (int i = 0; i < NPTS/2; i++) begin
      angle_q30(i, NPTS, c, s);
      twid_cos[i] = int'((c + 16384) >>> 15);
      twid_sin[i] = int'((-s + 16384) >>> 15);
    end
  endfunction

  function automatic longint clamp36(longint v);
    if (v > CLAMP_HI) return CLAMP_HI;
    if (v < CLAMP_LO) return CLAMP_LO;
    return v;
  endfunction

  function automatic longint twiddle_mul(longint a, int w);
    return (a * longint'(w) + 16384) >>> 15;
  endfunction

  function automatic void transform_frame();
    int r, half, stride, ia, ib, k;
    longint t, tr, ti, ar, ai;
    for (int i = 0; i < NPTS; i++) begin
      r = 0;
      for (int b = 0; b < 9; b++) r |= ((i >> b) & 1) << (8 - b);
      if (r > i) begin
        t = bin_re[i]; bin_re[i] = bin_re[r]; bin_re[r] = t;
        t = bin_im[i]; bin_im[i] = bin_im[r]; bin_im[r] = t;
      end
    end
    for (int len = 2; len <= NPTS; len <<= 1) begin
      half = len / 2;
      stride = NPTS / len;
      for (int st = 0; st < NPTS; st += len) begin
        for (int j = 0; j < half; j++) begin
          ia = st + j;
          ib = ia + half;
          k = (j * stride) % (NPTS/2);
          tr = twiddle_mul(bin_re[ib], twid_cos[k]) - twiddle_mul(bin_im[ib], twid_sin[k]);
          ti = twiddle_mul(bin_re[ib], twid_sin[k]) + twiddle_mul(bin_im[ib], twid_cos[k]);
          ar = bin_re[ia];
          ai = bin_im[ia];
          bin_re[ia] = clamp36(ar + tr);
          bin_im[ia] = clamp36(ai + ti);
          bin_re[ib] = clamp36(ar - tr);
          bin_im[ib] = clamp36(ai - ti);
        end
      end
    end
  endfunction

  function automatic logic [127:0] bin_power(int k);
    logic [127:0] re_mag, im_mag;
    k = k & (NPTS - 1);
    re_mag = (bin_re[k] < 0) ? 128'(-bin_re[k]) : 128'(bin_re[k]);
    im_mag = (bin_im[k] < 0) ? 128'(-bin_im[k]) : 128'(bin_im[k]);
    return re_mag * re_mag + im_mag * im_mag;
  endfunction

  // returns 1 when the word ends a frame, with the expected pitch
  function automatic bit predict_pitch(fsp_in_t w, output fsp_out_t res);
    longint x;
    logic [127:0] pp, pc, pn;
    res = '0;
    if (samples_in < NPTS) begin
      samples_held[samples_in] = int'(w.sample);
      samples_in++;
    end
    if (!w.last) return 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      x = (i < samples_in) ? longint'(samples_held[i]) : 0;
      bin_re[i] = clamp36((x * longint'(hann_rom[i]) + 64) >>> 7);
      bin_im[i] = 0;
    end
    samples_in = 0;
    transform_frame();
    for (int k = 2; k <= int'(bins_to_search) + 1; k++) begin
      pp = bin_power(k - 1);
      pc = bin_power(k);
      pn = bin_power(k + 1);
      if (pc >= pp && pn < pc) begin
        res.f0_hz = F0_W'(int'(hz_step) * (k - 1));
        res.peak_found = 1'b1;
        break;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_word(logic signed [15:0] smp, logic lst);
    fsp_in_t w;
    fsp_out_t res;
    w.sample = smp;
    w.last = lst;
    start <= 1'b1;
    frame_word <= w;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    words_sent++;
    if (predict_pitch(w, res)) begin
      pitch_q.push_back(res);
      frames_sent++;
    end
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (allow_gaps && $urandom_range(3) == 0) idle_cycles($urandom_range(12, 1));
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (pitch_q.size() != 0) @(posedge clk);
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HZ_PER_BIN) hz_step = val[5:0];
    else bins_to_search = val;
  endtask

  // a frame of len samples: square wave of half-period per, or noise when per is 0
  task automatic send_frame(int len, int per, int amp);
    logic signed [15:0] smp;
    for (int i = 0; i < len; i++) begin
      if (per == 0) smp = 16'($urandom);
      else smp = ((i / per) % 2) ? 16'(amp) : 16'(-amp);
      send_word(smp, i == len - 1);
      maybe_gap();
    end
  endtask

  always @(posedge clk) begin
    fsp_out_t want;
    if (!rst && done) begin
      if (pitch_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected pitch word %p", pitch_word);
      end else begin
        want = pitch_q.pop_front();
        if (pitch_word.f0_hz !== want.f0_hz || pitch_word.peak_found !== want.peak_found) begin
          fail_count++;
          if (fail_count <= 10)
            $display("pitch mismatch: expected f0 %0d found %0d, got f0 %0d found %0d",
                     want.f0_hz, want.peak_found, pitch_word.f0_hz, pitch_word.peak_found);
        end
      end
    end
  end

  task automatic test_default_config();
    send_frame(6, 2, 20000);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sd32768, 1'b1);
  endtask

  task automatic test_single_sample_frame();
    send_word(16'sh7fff, 1'b1);
    send_word(-16'sd32768, 1'b1);
  endtask

  task automatic test_reg_extremes();
    write_reg(REG_HZ_PER_BIN, 8'd63);
    write_reg(REG_SEARCH_BINS, 8'd255);
    send_frame(5, 1, 32767);
    write_reg(REG_HZ_PER_BIN, 8'd0);
    write_reg(REG_SEARCH_BINS, 8'd1);
    send_frame(4, 2, 30000);
  endtask

  task automatic test_no_candidate();
    write_reg(REG_SEARCH_BINS, 8'd0);
    send_frame(3, 1, 1000);
  endtask

  task automatic test_flat_frame();
    write_reg(REG_HZ_PER_BIN, 8'd31);
    write_reg(REG_SEARCH_BINS, 8'd50);
    send_word(16'sd0, 1'b0);
    send_word(16'sd0, 1'b1);
  endtask

  task automatic test_random_frames();
    int len, per;
    while (words_sent < 1700) begin
      allow_gaps = (words_sent < 1400);
      if ($urandom_range(4) == 0) begin
        write_reg(REG_HZ_PER_BIN, 8'($urandom_range(63)));
        write_reg(REG_SEARCH_BINS, 8'($urandom_range(255, 1)));
      end
      if (frames_sent % 15 == 7) len = NPTS + $urandom_range(20);
      else if (frames_sent % 15 == 12) len = NPTS;
      else len = $urandom_range(60, 8);
      if (words_sent + len > 1760) len = $urandom_range(60, 8);
      per = ($urandom_range(5) == 0) ? 0 : $urandom_range(40, 1);
      send_frame(len, per, $urandom_range(32767));
      if (frames_sent % 10 == 5) wait_quiet();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    frame_word = '0;
    cfg_we = 1'b0;
    cfg_index = REG_HZ_PER_BIN;
    cfg_data = '0;
    fail_count = 0;
    words_sent = 0;
    frames_sent = 0;
    allow_gaps = 1'b0;
    samples_in = 0;
    hz_step = HZ_RESET;
    bins_to_search = BINS_RESET;
    fill_trig_tables();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_config();
    test_single_sample_frame();
    test_reg_extremes();
    test_no_candidate();
    test_flat_frame();
    test_random_frames();
    wait_quiet();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(64'd300_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
